### sv/wws_pkg.sv
// Shared types, cell codes and next-state helpers for the Wireworld stencil.
// No dependencies; used by the top level and the bench.
`timescale 1ns / 1ps

package wws_pkg;

  localparam int DIM_W  = 7;   // width of a grid dimension or a row/column counter
  localparam int POS_W  = 6;   // width of a result row or column
  localparam int SLOTS  = 4;   // results one input can cause
  localparam int CNT_W  = 3;   // holds 0..SLOTS

  typedef logic [1:0]       cell_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       reg_idx_t;

  localparam cell_t ST_EMPTY  = 2'd0;
  localparam cell_t ST_HEAD   = 2'd1;
  localparam cell_t ST_TAIL   = 2'd2;
  localparam cell_t ST_COPPER = 2'd3;

  localparam reg_idx_t REG_GRID_ROWS = 2'd0;
  localparam reg_idx_t REG_GRID_COLS = 2'd1;

  localparam dim_t DIM_RESET = 7'd40;
  localparam dim_t DIM_MIN   = 7'd2;

  typedef struct packed {
    cell_t state;
    pos_t  row;
    pos_t  col;
    logic  done;
  } result_t;

  // Clamp a written dimension into 2..maxv.
  function automatic dim_t clamp_dim(dim_t v, int unsigned maxv);
    dim_t res;
    res = v;
    if (v < DIM_MIN) begin
      res = DIM_MIN;
    end else if (32'(v) > maxv) begin
      res = dim_t'(maxv);
    end
    return res;
  endfunction

  function automatic logic [3:0] count_heads(logic [7:0] h);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(h[i]);
    end
    return n;
  endfunction

  function automatic cell_t next_cell(cell_t center, logic [3:0] heads);
    cell_t res;
    case (center)
      ST_EMPTY: res = ST_EMPTY;
      ST_HEAD:  res = ST_TAIL;
      ST_TAIL:  res = ST_COPPER;
      default:  res = (heads == 4'd1 || heads == 4'd2) ? ST_HEAD : ST_COPPER;
    endcase
    return res;
  endfunction

endpackage

### sv/wws_line_store.sv
// Line store: single-port-write, single-port-read memory, registered read.
// Depends on nothing; holds the two rows above the current one.
`timescale 1ns / 1ps

module wws_line_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/wireworld_stencil_step_unit.sv
// Top level of the Wireworld stencil: counters, 3x3 window, result queue.
// Depends on wws_pkg and wws_line_store.
`timescale 1ns / 1ps

// Usage
//   Stream one grid generation in raster order, one 2-bit cell per input beat
//   (0 empty, 1 head, 2 tail, 3 copper). Each input beat causes 0 to 4 result
//   beats carrying a cell's next state with its row and column; run_last marks
//   the final result of an input beat, frame_done the grid's last cell.
//   Results trail the input by one row and one column; end-of-row and
//   last-row inputs also flush the cells that remain.
//   Set grid_rows / grid_cols through the cfg port while idle; writing either
//   restarts the frame at row 0, column 0. Values clamp to 2..MAX.
// Timing
//   An accepted beat reads the line store into the read stage, then, once the
//   output queue is free, updates the window and loads its results into the
//   queue, whose slot 0 drives out_*. Throughput is one input beat per cycle
//   while the receiver takes every result and each beat causes at most one;
//   a beat with several results holds the next beat until the last one leaves.
//   When the receiver stalls, the queue holds and in_ready drops once the
//   read stage is full. Reset clears counters, window and queue; the line
//   store needs no clearing since stale entries only stand for cells outside
//   the grid.
module wireworld_stencil_step_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  wws_pkg::reg_idx_t       cfg_index,
  input  logic [wws_pkg::DIM_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cell_state,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_next_state,
  output logic [5:0]              out_cell_row,
  output logic [5:0]              out_cell_col,
  output logic                    out_run_last,
  output logic                    out_frame_done
);

  localparam int COLS_CAP = (MAX_COLS < 128) ? MAX_COLS : 128;
  localparam int AW       = (COLS_CAP > 2) ? $clog2(COLS_CAP) : 1;

  // Grid size and raster position
  wws_pkg::dim_t rows_r, rows_nxt, cols_r, cols_nxt;
  wws_pkg::dim_t row_r, row_nxt, col_r, col_nxt;

  logic in_acc, end_col_a, last_row_a, restart;

  // Read stage: beat waits here for line store data
  logic           b_valid_r, b_valid_nxt, b_adv;
  wws_pkg::cell_t cur_b_r;
  wws_pkg::dim_t  row_b_r, col_b_r;
  logic           end_b_r, last_b_r;
  logic [3:0]     line_rd;

  // 3x3 window: [0] row r-2, [1] row r-1, [2] row r; [..][2] newest column
  wws_pkg::cell_t win_r [3][3];
  wws_pkg::cell_t win_nxt [3][3];
  logic           hd [3][3];
  logic           row0_ok, col0_ok;

  logic             cand_v [wws_pkg::SLOTS];
  wws_pkg::result_t cand   [wws_pkg::SLOTS];
  wws_pkg::result_t slot_nxt [wws_pkg::SLOTS];
  wws_pkg::cnt_t    n_res;
  wws_pkg::dim_t    row_m1, col_m1;

  // Output queue: slot 0 drives the ports
  wws_pkg::result_t q_r [wws_pkg::SLOTS];
  wws_pkg::cnt_t    q_left_r, q_left_nxt;
  logic             q_free, out_pop;

  // ---------------------------------------------------------------- config
  assign restart = cfg_we &&
                   (cfg_index == wws_pkg::REG_GRID_ROWS || cfg_index == wws_pkg::REG_GRID_COLS);

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we && cfg_index == wws_pkg::REG_GRID_ROWS) begin
      rows_nxt = wws_pkg::clamp_dim(cfg_wdata, MAX_ROWS);
    end
    if (cfg_we && cfg_index == wws_pkg::REG_GRID_COLS) begin
      cols_nxt = wws_pkg::clamp_dim(cfg_wdata, COLS_CAP);
    end
  end

  // ------------------------------------------------------------ input side
  assign q_free   = (q_left_r == '0) || (out_ready && q_left_r == wws_pkg::cnt_t'(1));
  assign b_adv    = b_valid_r && q_free;
  assign in_ready = !b_valid_r || b_adv;
  assign in_acc   = in_valid && in_ready;

  assign end_col_a  = (col_r >= cols_r - wws_pkg::dim_t'(1));
  assign last_row_a = (row_r >= rows_r - wws_pkg::dim_t'(1));

  // advance raster position; wrap at row end and frame end; back to 0,0 on a size write
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (end_col_a) begin
        col_nxt = '0;
        row_nxt = last_row_a ? '0 : row_r + wws_pkg::dim_t'(1);
      end else begin
        col_nxt = col_r + wws_pkg::dim_t'(1);
      end
    end
  end

  assign b_valid_nxt = in_acc ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= wws_pkg::clamp_dim(wws_pkg::DIM_RESET, MAX_ROWS);
      cols_r    <= wws_pkg::clamp_dim(wws_pkg::DIM_RESET, COLS_CAP);
      row_r     <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_b_r  <= in_cell_state;
      row_b_r  <= row_r;
      col_b_r  <= col_r;
      end_b_r  <= end_col_a;
      last_b_r <= last_row_a;
    end
  end

  // Line store word: {row two above, row above}. Read on accept, write back
  // the shifted pair when the beat leaves the read stage. The same column is
  // touched again only a full row later, so no forwarding is needed.
  wws_line_store #(
    .DEPTH (COLS_CAP),
    .AW    (AW),
    .W     (4)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r[AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (b_adv),
    .wr_addr (col_b_r[AW-1:0]),
    .wr_data ({line_rd[1:0], cur_b_r})
  );

  // ---------------------------------------------------------------- window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = line_rd[3:2];
    win_nxt[1][2] = line_rd[1:0];
    win_nxt[2][2] = cur_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= wws_pkg::ST_EMPTY;
        end
      end
    end else if (b_adv) begin
      win_r <= win_nxt;
    end
  end

  // Drop neighbors above the top row or left of column 0. The bottom row
  // and right column of the window never lie outside the grid.
  assign row0_ok = (row_b_r >= wws_pkg::dim_t'(2));
  assign col0_ok = (col_b_r >= wws_pkg::dim_t'(2));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hd[i][j] = (win_nxt[i][j] == wws_pkg::ST_HEAD);
      end
    end
    for (int j = 0; j < 3; j++) begin
      hd[0][j] = hd[0][j] && row0_ok;
    end
    for (int i = 0; i < 3; i++) begin
      hd[i][0] = hd[i][0] && col0_ok;
    end
  end

  assign row_m1 = row_b_r - wws_pkg::dim_t'(1);
  assign col_m1 = col_b_r - wws_pkg::dim_t'(1);

  // Four candidate results in output order
  always_comb begin
    cand_v[0] = (row_b_r != '0) && (col_b_r != '0);
    cand[0].state = wws_pkg::next_cell(win_nxt[1][1], wws_pkg::count_heads(
        {hd[0][0], hd[0][1], hd[0][2], hd[1][0], hd[1][2], hd[2][0], hd[2][1], hd[2][2]}));
    cand[0].row  = row_m1[wws_pkg::POS_W-1:0];
    cand[0].col  = col_m1[wws_pkg::POS_W-1:0];
    cand[0].done = 1'b0;

    cand_v[1] = (row_b_r != '0) && end_b_r;
    cand[1].state = wws_pkg::next_cell(win_nxt[1][2], wws_pkg::count_heads(
        {3'b000, hd[0][1], hd[0][2], hd[1][1], hd[2][1], hd[2][2]}));
    cand[1].row  = row_m1[wws_pkg::POS_W-1:0];
    cand[1].col  = col_b_r[wws_pkg::POS_W-1:0];
    cand[1].done = 1'b0;

    cand_v[2] = last_b_r && (col_b_r != '0);
    cand[2].state = wws_pkg::next_cell(win_nxt[2][1], wws_pkg::count_heads(
        {3'b000, hd[1][0], hd[1][1], hd[1][2], hd[2][0], hd[2][2]}));
    cand[2].row  = row_b_r[wws_pkg::POS_W-1:0];
    cand[2].col  = col_m1[wws_pkg::POS_W-1:0];
    cand[2].done = 1'b0;

    cand_v[3] = last_b_r && end_b_r;
    cand[3].state = wws_pkg::next_cell(win_nxt[2][2], wws_pkg::count_heads(
        {5'b00000, hd[1][1], hd[1][2], hd[2][1]}));
    cand[3].row  = row_b_r[wws_pkg::POS_W-1:0];
    cand[3].col  = col_b_r[wws_pkg::POS_W-1:0];
    cand[3].done = 1'b1;
  end

  // pack the live candidates toward slot 0
  always_comb begin
    n_res = '0;
    for (int k = 0; k < wws_pkg::SLOTS; k++) begin
      slot_nxt[k] = cand[k];
    end
    for (int k = 0; k < wws_pkg::SLOTS; k++) begin
      if (cand_v[k]) begin
        slot_nxt[n_res[1:0]] = cand[k];
        n_res = n_res + wws_pkg::cnt_t'(1);
      end
    end
  end

  // ---------------------------------------------------------- output queue
  assign out_valid = (q_left_r != '0);
  assign out_pop   = out_valid && out_ready;

  always_comb begin
    q_left_nxt = q_left_r;
    if (b_adv) begin
      q_left_nxt = n_res;
    end else if (out_pop) begin
      q_left_nxt = q_left_r - wws_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_left_r <= '0;
    end else begin
      q_left_r <= q_left_nxt;
    end
  end

  // load a fresh set, or shift the next result up on a pop
  always_ff @(posedge clk) begin
    if (b_adv) begin
      q_r <= slot_nxt;
    end else if (out_pop) begin
      for (int k = 0; k < wws_pkg::SLOTS - 1; k++) begin
        q_r[k] <= q_r[k+1];
      end
    end
  end

  assign out_next_state = q_r[0].state;
  assign out_cell_row   = q_r[0].row;
  assign out_cell_col   = q_r[0].col;
  assign out_frame_done = q_r[0].done;
  assign out_run_last   = (q_left_r == wws_pkg::cnt_t'(1));

endmodule

### bench/tb_top.sv
// Self-checking bench for wireworld_stencil_step_unit: streams grids, predicts each result beat.
// Depends on wws_pkg and the block's RTL; needs no other file.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID_MAX      = 64;      // matches the block's MAX_ROWS / MAX_COLS
  localparam int SETTLE_CYCLES = 10;      // covers read stage plus output queue
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off for the pressure test
  localparam int LIMIT_CYCLES  = 400000;  // run ceiling, several times the slowest run
  localparam int RANDOM_ITEMS  = 84;      // brings the whole run to about 280 cells

  // Index 3 maps to no register; a write there must leave the frame alone.
  localparam wws_pkg::reg_idx_t REG_UNUSED = 2'd3;

  typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  // One predicted result beat.
  typedef struct {
    wws_pkg::cell_t state;
    wws_pkg::pos_t  row;
    wws_pkg::pos_t  col;
    logic           run_last;
    logic           frame_done;
  } cell_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  wws_pkg::reg_idx_t cfg_index = wws_pkg::REG_GRID_ROWS;
  wws_pkg::dim_t     cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cell_state = 2'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_next_state;
  logic [5:0]        out_cell_row;
  logic [5:0]        out_cell_col;
  logic              out_run_last;
  logic              out_frame_done;

  wireworld_stencil_step_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_state (in_cell_state),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_state(out_next_state),
    .out_cell_row  (out_cell_row),
    .out_cell_col  (out_cell_col),
    .out_run_last  (out_run_last),
    .out_frame_done(out_frame_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Generation predictor: its own copy of the registers, line stores, window
  // and raster position. Line stores start empty; entries never written only
  // ever stand for rows outside the grid, so their content cannot matter.
  // ---------------------------------------------------------------------------
  wws_pkg::dim_t  rows_cfg = wws_pkg::DIM_RESET;
  wws_pkg::dim_t  cols_cfg = wws_pkg::DIM_RESET;
  wws_pkg::cell_t above_line [GRID_MAX] = '{default: wws_pkg::ST_EMPTY};
  wws_pkg::cell_t two_above_line [GRID_MAX] = '{default: wws_pkg::ST_EMPTY};
  wws_pkg::cell_t win [3][3] = '{default: '{default: wws_pkg::ST_EMPTY}};
  int             row_pos = 0;
  int             col_pos = 0;

  cell_result_t next_gen_q [$];   // next-generation cells still owed by the block
  int           fail_count = 0;

  // Out-of-range register values act as the nearest legal size.
  function automatic int eff_size(wws_pkg::dim_t v);
    if (v < 7'd2) return 2;
    if (int'(v) > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // Next state of cell (tr,tc) while the window's bottom-right cell is (r,c).
  function automatic wws_pkg::cell_t evolve(int tr, int tc, int r, int c, int rows, int cols);
    wws_pkg::cell_t mid_cell;
    int             heads;
    int             y;
    int             x;
    mid_cell = win[tr - r + 2][tc - c + 2];
    case (mid_cell)
      wws_pkg::ST_EMPTY: return wws_pkg::ST_EMPTY;
      wws_pkg::ST_HEAD:  return wws_pkg::ST_TAIL;
      wws_pkg::ST_TAIL:  return wws_pkg::ST_COPPER;
      default:  ;
    endcase
    heads = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y = tr + dy;
        x = tc + dx;
        // skip the center itself and anything off the grid or out of the window
        if (dy == 0 && dx == 0) continue;
        if (y < 0 || x < 0 || y >= rows || x >= cols) continue;
        if (y < r - 2 || y > r || x < c - 2 || x > c) continue;
        if (win[y - r + 2][x - c + 2] == wws_pkg::ST_HEAD) heads++;
      end
    end
    return (heads == 1 || heads == 2) ? wws_pkg::ST_HEAD : wws_pkg::ST_COPPER;
  endfunction

  function automatic void owe_cell(int tr, int tc, int r, int c, int rows, int cols,
                                   logic done);
    cell_result_t res;
    res.state      = evolve(tr, tc, r, c, rows, cols);
    res.row        = wws_pkg::pos_t'(tr);
    res.col        = wws_pkg::pos_t'(tc);
    res.run_last   = 1'b0;
    res.frame_done = done;
    next_gen_q.push_back(res);
  endfunction

  // Advance the predictor by one accepted cell and queue the results it causes.
  function automatic void advance_grid(wws_pkg::cell_t cur);
    int rows;
    int cols;
    int r;
    int c;
    int owed_before;
    bit end_col;
    bit last_row;
    rows = eff_size(rows_cfg);
    cols = eff_size(cols_cfg);
    r = row_pos;
    c = col_pos;
    if (c > cols - 1) c = cols - 1;
    if (r > rows - 1) r = rows - 1;
    end_col  = (c == cols - 1);
    last_row = (r == rows - 1);

    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = two_above_line[c];
    win[1][2] = above_line[c];
    win[2][2] = cur;
    two_above_line[c] = above_line[c];
    above_line[c] = cur;

    owed_before = next_gen_q.size();
    if (r >= 1 && c >= 1) owe_cell(r - 1, c - 1, r, c, rows, cols, 1'b0);
    if (r >= 1 && end_col) owe_cell(r - 1, c, r, c, rows, cols, 1'b0);
    if (last_row && c >= 1) owe_cell(r, c - 1, r, c, rows, cols, 1'b0);
    if (last_row && end_col) owe_cell(r, c, r, c, rows, cols, 1'b1);
    if (next_gen_q.size() > owed_before) next_gen_q[$].run_last = 1'b1;

    if (end_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps when gaps are enabled.
  // Every task below is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  bit tx_gaps_on = 1'b1;
  int burst_left = 0;

  task automatic send_cell(input wws_pkg::cell_t value);
    if (tx_gaps_on && burst_left == 0) begin
      // drop valid for a gap, then start a new burst
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_cell_state <= value;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    advance_grid(value);
  endtask

  // Register write; the extra cycle keeps back-to-back writes to one assignment per edge.
  task automatic write_reg(input wws_pkg::reg_idx_t idx, input wws_pkg::dim_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == wws_pkg::REG_GRID_ROWS || idx == wws_pkg::REG_GRID_COLS) begin
      if (idx == wws_pkg::REG_GRID_ROWS) rows_cfg = value;
      else cols_cfg = value;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // Hold valid low until every owed result has arrived, then let in-flight
  // beats that cause no result drain out of the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Weighted toward copper and heads so the firing rule gets plenty of work.
  function automatic wws_pkg::cell_t random_cell();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return wws_pkg::ST_EMPTY;
    if (pick < 5) return wws_pkg::ST_HEAD;
    if (pick < 6) return wws_pkg::ST_TAIL;
    return wws_pkg::ST_COPPER;
  endfunction

  // Mostly small sizes; now and then the maximum or a value that must clamp.
  function automatic wws_pkg::dim_t pick_dim(bit allow_big);
    case ($urandom_range(0, 11))
      0:       return allow_big ? wws_pkg::dim_t'(GRID_MAX)
                                : wws_pkg::dim_t'($urandom_range(2, 7));
      1:       return allow_big ? wws_pkg::dim_t'($urandom_range(65, 127))
                                : wws_pkg::dim_t'(7'd2);
      2:       return wws_pkg::dim_t'($urandom_range(0, 1));
      default: return wws_pkg::dim_t'($urandom_range(2, 7));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own shifting pattern; serves long hold-off requests.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_cycle = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       hold_left = 0;

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_cycle % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_STEADY:   out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= ($urandom_range(0, 9) >= 4);
        RX_PERIODIC: out_ready <= (rx_cycle % 3 != 0);
        default:     out_ready <= ($urandom_range(0, 9) >= 8);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted beat against the oldest owed cell.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cell_result_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (next_gen_q.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got row %0d col %0d",
                 $time, out_cell_row, out_cell_col);
        fail_count++;
      end else begin
        exp_beat = next_gen_q.pop_front();
        if (out_next_state !== exp_beat.state)
          report_mismatch("next_state", 8'(exp_beat.state), 8'(out_next_state));
        if (out_cell_row !== exp_beat.row)
          report_mismatch("cell_row", 8'(exp_beat.row), 8'(out_cell_row));
        if (out_cell_col !== exp_beat.col)
          report_mismatch("cell_col", 8'(exp_beat.col), 8'(out_cell_col));
        if (out_run_last !== exp_beat.run_last)
          report_mismatch("run_last", 8'(exp_beat.run_last), 8'(out_run_last));
        if (out_frame_done !== exp_beat.frame_done)
          report_mismatch("frame_done", 8'(exp_beat.frame_done), 8'(out_frame_done));
      end
    end
  end

  // Cycle ceiling: a hung handshake ends the run as a failure.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the grid is 40x40: stream a partial frame of a few rows.
  task automatic test_reset_size();
    for (int i = 0; i < 100; i++) send_cell(random_cell());
    wait_idle();
  endtask

  // Writes of 0 and 1 clamp to a 2x2 grid. Frames: copper with three heads
  // (stays copper), all four states with one head next to copper (fires),
  // copper pair with two heads each (fires).
  task automatic test_rule_cases();
    wws_pkg::cell_t frames [12];
    frames = '{wws_pkg::ST_COPPER, wws_pkg::ST_HEAD, wws_pkg::ST_HEAD, wws_pkg::ST_HEAD,
               wws_pkg::ST_COPPER, wws_pkg::ST_HEAD, wws_pkg::ST_EMPTY, wws_pkg::ST_TAIL,
               wws_pkg::ST_HEAD, wws_pkg::ST_COPPER, wws_pkg::ST_COPPER, wws_pkg::ST_HEAD};
    write_reg(wws_pkg::REG_GRID_ROWS, 7'd0);
    write_reg(wws_pkg::REG_GRID_COLS, 7'd1);
    foreach (frames[i]) send_cell(frames[i]);
    wait_idle();
  endtask

  // A write to an unmapped index leaves the frame running; a real write
  // restarts it at the origin. The full frame is copper ringed by eight heads.
  task automatic test_frame_restart();
    wws_pkg::cell_t ring [9];
    ring = '{wws_pkg::ST_HEAD, wws_pkg::ST_HEAD, wws_pkg::ST_HEAD,
             wws_pkg::ST_HEAD, wws_pkg::ST_COPPER, wws_pkg::ST_HEAD,
             wws_pkg::ST_HEAD, wws_pkg::ST_HEAD, wws_pkg::ST_HEAD};
    write_reg(wws_pkg::REG_GRID_ROWS, 7'd3);
    write_reg(wws_pkg::REG_GRID_COLS, 7'd3);
    for (int i = 0; i < 4; i++) send_cell(random_cell());
    wait_idle();
    write_reg(REG_UNUSED, 7'h55);
    send_cell(wws_pkg::ST_COPPER);
    wait_idle();
    write_reg(wws_pkg::REG_GRID_COLS, 7'd3);
    foreach (ring[i]) send_cell(ring[i]);
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while the sender streams with no
  // gaps, so the block fills and drops in_ready.
  task automatic test_backpressure();
    write_reg(wws_pkg::REG_GRID_ROWS, 7'd5);
    write_reg(wws_pkg::REG_GRID_COLS, 7'd7);
    tx_gaps_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 70; i++) send_cell(random_cell());
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  // Random sizes and content: whole frames, repeated frames and frames cut short.
  task automatic test_random_frames();
    int            sent;
    int            frame_len;
    wws_pkg::dim_t rows_w;
    wws_pkg::dim_t cols_w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      rows_w = pick_dim(1'b1);
      cols_w = pick_dim(eff_size(rows_w) <= 8);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(wws_pkg::REG_GRID_ROWS, rows_w);
        write_reg(wws_pkg::REG_GRID_COLS, cols_w);
      end else begin
        write_reg(wws_pkg::REG_GRID_COLS, cols_w);
        write_reg(wws_pkg::REG_GRID_ROWS, rows_w);
      end
      frame_len = eff_size(rows_w) * eff_size(cols_w) * $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0) frame_len = $urandom_range(1, frame_len - 1);
      // keep the whole run near its cell budget
      if (frame_len > RANDOM_ITEMS - sent) frame_len = RANDOM_ITEMS - sent;
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < frame_len; i++) send_cell(random_cell());
      sent += frame_len;
      wait_idle();
    end
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_rule_cases();
    test_frame_restart();
    test_backpressure();
    test_random_frames();

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### wireworld_stencil_step_unit.f
sv/wws_pkg.sv
sv/wws_line_store.sv
sv/wireworld_stencil_step_unit.sv
bench/tb_top.sv
